[rtl/core/falling_cell_grid_sweep_top_assert.svh]
`ifndef FALLING_CELL_GRID_SWEEP_TOP_ASSERT_SVH
`define FALLING_CELL_GRID_SWEEP_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FCGS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcgs check failed");

// Next-cycle implication.
`define FCGS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcgs check failed");

`endif

[rtl/core/fcgs_pkg.sv]
package fcgs_pkg;

    localparam int CHAR_W       = 8;
    localparam int IDX_W        = 6;
    localparam int CFG_W        = 7;
    localparam int CNT_W        = 9;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 16;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CFG_W-1:0]  CFG_RESET  = 7'd64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FALL  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } reg_idx_t;

    // RAM address source
    typedef enum logic [2:0] {
        A_SRC   = 3'd0,
        A_DOWN  = 3'd1,
        A_LEFT  = 3'd2,
        A_RIGHT = 3'd3,
        A_DST   = 3'd4,
        A_IO    = 3'd5,
        A_CLR   = 3'd6
    } asel_t;

    typedef enum logic [1:0] {
        W_SPACE = 2'd0,
        W_CHAR  = 2'd1,
        W_V     = 2'd2
    } wsel_t;

    typedef enum logic [1:0] {
        D_DOWN  = 2'd0,
        D_LEFT  = 2'd1,
        D_RIGHT = 2'd2
    } dsel_t;

    typedef struct packed {
        logic    take_in;
        logic    we;
        asel_t   asel;
        wsel_t   wsel;
        logic    cap_read;
        logic    sw_init;
        logic    cap_v;
        logic    set_dsel;
        dsel_t   dsel;
        logic    next_cell;
        logic    clr_inc;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        opcode_t in_op;
        logic    in_grid;
        logic    rd_space;
        logic    sweep_empty;
        logic    c_first;
        logic    c_last;
        logic    r_last;
        logic    clr_last;
        logic    out_free;
    } dp_status_t;

endpackage

[rtl/core/fcgs_ram.sv]
module fcgs_ram #(
    parameter int WIDTH = fcgs_pkg::CHAR_W,
    parameter int DEPTH = fcgs_pkg::DEF_MAX_ROWS * fcgs_pkg::DEF_MAX_COLS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fcgs_regs.sv]
module fcgs_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcgs_pkg::APB_AW-1:0] paddr,
    input  logic [fcgs_pkg::APB_DW-1:0] pwdata,
    output logic [fcgs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [fcgs_pkg::CFG_W-1:0]  cols_cfg,
    output logic [fcgs_pkg::CFG_W-1:0]  rows_cfg
);
    import fcgs_pkg::*;

    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] cols_next;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] rows_next;
    logic             wr_en;
    reg_idx_t         idx;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COLS: cols_next = pwdata[CFG_W-1:0];
                REG_ROWS: rows_next = pwdata[CFG_W-1:0];
                default:  cols_next = cols_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COLS: prdata = APB_DW'(cols_reg);
            REG_ROWS: prdata = APB_DW'(rows_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_RESET;
            rows_reg <= CFG_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    assign cols_cfg = cols_reg;
    assign rows_cfg = rows_reg;

endmodule

[rtl/core/fcgs_ctrl.sv]
`include "falling_cell_grid_sweep_top_assert.svh"

module fcgs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fcgs_pkg::dp_status_t status,
    output fcgs_pkg::ctrl_cmd_t  cmd
);
    import fcgs_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_WRITE    = 14'b00000000000100,
        S_READ     = 14'b00000000001000,
        S_READ_CAP = 14'b00000000010000,
        S_SW_START = 14'b00000000100000,
        S_SW_SRC   = 14'b00000001000000,
        S_SW_CHK   = 14'b00000010000000,
        S_SW_DOWN  = 14'b00000100000000,
        S_SW_LEFT  = 14'b00001000000000,
        S_SW_RIGHT = 14'b00010000000000,
        S_SW_WDST  = 14'b00100000000000,
        S_SW_WSRC  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_cell;
    logic   we_state;

    // where to go once the current cell is finished
    assign after_cell = (status.c_last && status.r_last) ? S_DONE : S_SW_SRC;
    assign in_ready   = (state_reg == S_IDLE);
    assign we_state   = (state_reg == S_CLEAR) || (state_reg == S_WRITE) ||
                        (state_reg == S_SW_WDST) || (state_reg == S_SW_WSRC);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.we      = 1'b1;
                cmd.asel    = A_CLR;
                cmd.wsel    = W_SPACE;
                cmd.clr_inc = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    unique case (status.in_op)
                        OP_WRITE: state_next = S_WRITE;
                        OP_READ:  state_next = S_READ;
                        OP_FALL:  state_next = S_SW_START;
                        OP_NONE:  state_next = S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.we     = status.in_grid;
                cmd.asel   = A_IO;
                cmd.wsel   = W_CHAR;
                state_next = S_DONE;
            end
            S_READ:
            begin
                cmd.asel   = A_IO;
                state_next = S_READ_CAP;
            end
            S_READ_CAP:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_DONE;
            end
            S_SW_START:
            begin
                if (status.sweep_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sw_init = 1'b1;
                    state_next  = S_SW_SRC;
                end
            end
            S_SW_SRC:
            begin
                cmd.asel   = A_SRC;
                state_next = S_SW_CHK;
            end
            S_SW_CHK:
            begin
                if (status.rd_space)
                begin
                    cmd.next_cell = 1'b1;
                    state_next    = after_cell;
                end
                else
                begin
                    cmd.cap_v  = 1'b1;
                    cmd.asel   = A_DOWN;
                    state_next = S_SW_DOWN;
                end
            end
            S_SW_DOWN:
            begin
                priority if (status.rd_space)
                begin
                    cmd.set_dsel = 1'b1;
                    cmd.dsel     = D_DOWN;
                    state_next   = S_SW_WDST;
                end
                else if (!status.c_first)
                begin
                    cmd.asel   = A_LEFT;
                    state_next = S_SW_LEFT;
                end
                else if (!status.c_last)
                begin
                    cmd.asel   = A_RIGHT;
                    state_next = S_SW_RIGHT;
                end
                else
                begin
                    cmd.next_cell = 1'b1;
                    state_next    = after_cell;
                end
            end
            S_SW_LEFT:
            begin
                priority if (status.rd_space)
                begin
                    cmd.set_dsel = 1'b1;
                    cmd.dsel     = D_LEFT;
                    state_next   = S_SW_WDST;
                end
                else if (!status.c_last)
                begin
                    cmd.asel   = A_RIGHT;
                    state_next = S_SW_RIGHT;
                end
                else
                begin
                    cmd.next_cell = 1'b1;
                    state_next    = after_cell;
                end
            end
            S_SW_RIGHT:
            begin
                if (status.rd_space)
                begin
                    cmd.set_dsel = 1'b1;
                    cmd.dsel     = D_RIGHT;
                    state_next   = S_SW_WDST;
                end
                else
                begin
                    cmd.next_cell = 1'b1;
                    state_next    = after_cell;
                end
            end
            S_SW_WDST:
            begin
                cmd.we     = 1'b1;
                cmd.asel   = A_DST;
                cmd.wsel   = W_V;
                state_next = S_SW_WSRC;
            end
            S_SW_WSRC:
            begin
                // leave a space behind the moved cell
                cmd.we        = 1'b1;
                cmd.asel      = A_SRC;
                cmd.wsel      = W_SPACE;
                cmd.next_cell = 1'b1;
                state_next    = after_cell;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FCGS_ASSERT_IMP(a_we_states, cmd.we, we_state)
    `FCGS_ASSERT_NXT(a_wdst_then_wsrc, state_reg == S_SW_WDST, cmd.we && (cmd.asel == A_SRC) && (cmd.wsel == W_SPACE))
    `FCGS_ASSERT_NXT(a_accept_leaves_idle, (state_reg == S_IDLE) && in_valid, state_reg != S_IDLE)

endmodule

[rtl/core/fcgs_dp.sv]
module fcgs_dp #(
    parameter int MAX_ROWS = fcgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = fcgs_pkg::DEF_MAX_COLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fcgs_pkg::ctrl_cmd_t              cmd,
    output fcgs_pkg::dp_status_t             status,
    input  logic [fcgs_pkg::IN_TDATA_W-1:0]  in_data,
    input  logic [fcgs_pkg::CFG_W-1:0]       cols_cfg,
    input  logic [fcgs_pkg::CFG_W-1:0]       rows_cfg,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fcgs_pkg::OUT_TDATA_W-1:0] out_data
);
    import fcgs_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // latched item
    opcode_t            op_reg,   op_next;
    logic [IDX_W-1:0]   row_reg,  row_next;
    logic [IDX_W-1:0]   col_reg,  col_next;
    logic [CHAR_W-1:0]  chr_reg,  chr_next;
    logic [CHAR_W-1:0]  res_reg,  res_next;
    // sweep position and moving cell
    logic [RW-1:0]      r_reg,    r_next;
    logic [CIW-1:0]     c_reg,    c_next;
    logic [CHAR_W-1:0]  v_reg,    v_next;
    dsel_t              dsel_reg, dsel_next;
    // clearing pass and output stage
    logic [AW-1:0]      clr_reg,  clr_next;
    logic               ov_reg,   ov_next;
    logic [CHAR_W-1:0]  oc_reg,   oc_next;
    opcode_t            oop_reg,  oop_next;

    logic [CNT_W-1:0]   nr;
    logic [CNT_W-1:0]   nc;
    logic [RW-1:0]      row_sel;
    logic [CIW-1:0]     col_sel;
    logic [AW-1:0]      grid_addr;
    logic [AW-1:0]      ram_addr;
    logic [CHAR_W-1:0]  ram_wdata;
    logic [CHAR_W-1:0]  ram_rdata;
    logic               in_grid;

    assign nr = (CNT_W'(rows_cfg) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_cfg);
    assign nc = (CNT_W'(cols_cfg) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cols_cfg);

    assign in_grid = (CNT_W'(row_reg) < CNT_W'(MAX_ROWS)) &&
                     (CNT_W'(col_reg) < CNT_W'(MAX_COLS));

    always_comb
    begin
        row_sel = r_reg;
        col_sel = c_reg;
        unique case (cmd.asel)
            A_SRC:   row_sel = r_reg - RW'(1);
            A_DOWN:  col_sel = c_reg;
            A_LEFT:  col_sel = c_reg - CIW'(1);
            A_RIGHT: col_sel = c_reg + CIW'(1);
            A_DST:
            begin
                unique case (dsel_reg)
                    D_LEFT:  col_sel = c_reg - CIW'(1);
                    D_RIGHT: col_sel = c_reg + CIW'(1);
                    default: col_sel = c_reg;
                endcase
            end
            A_IO:
            begin
                row_sel = RW'(row_reg);
                col_sel = CIW'(col_reg);
            end
            default:
            begin
                row_sel = '0;
                col_sel = '0;
            end
        endcase
    end

    assign grid_addr = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);
    assign ram_addr  = (cmd.asel == A_CLR) ? clr_reg : grid_addr;

    always_comb
    begin
        unique case (cmd.wsel)
            W_CHAR:  ram_wdata = chr_reg;
            W_V:     ram_wdata = v_reg;
            default: ram_wdata = SPACE_CHAR;
        endcase
    end

    fcgs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        op_next   = op_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        chr_next  = chr_reg;
        res_next  = res_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        v_next    = v_reg;
        dsel_next = dsel_reg;
        clr_next  = clr_reg;
        oc_next   = oc_reg;
        oop_next  = oop_reg;
        ov_next   = ov_reg && !out_ready;

        if (cmd.take_in)
        begin
            op_next  = opcode_t'(in_data[1:0]);
            row_next = in_data[7:2];
            col_next = in_data[13:8];
            chr_next = in_data[21:14];
            res_next = '0;
        end
        if (cmd.cap_read)
        begin
            res_next = in_grid ? ram_rdata : SPACE_CHAR;
        end
        if (cmd.sw_init)
        begin
            r_next = RW'(nr - CNT_W'(1));
            c_next = '0;
        end
        if (cmd.cap_v)
        begin
            v_next = ram_rdata;
        end
        if (cmd.set_dsel)
        begin
            dsel_next = cmd.dsel;
        end
        if (cmd.next_cell)
        begin
            if (status.c_last)
            begin
                c_next = '0;
                r_next = r_reg - RW'(1);
            end
            else
            begin
                c_next = c_reg + CIW'(1);
            end
        end
        if (cmd.clr_inc)
        begin
            clr_next = clr_reg + AW'(1);
        end
        if (cmd.out_load)
        begin
            ov_next  = 1'b1;
            oc_next  = res_reg;
            oop_next = op_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            clr_reg <= clr_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        chr_reg  <= chr_next;
        res_reg  <= res_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        v_reg    <= v_next;
        dsel_reg <= dsel_next;
        oc_reg   <= oc_next;
        oop_reg  <= oop_next;
    end

    always_comb
    begin
        status             = '0;
        status.in_op       = opcode_t'(in_data[1:0]);
        status.in_grid     = in_grid;
        status.rd_space    = (ram_rdata == SPACE_CHAR);
        status.sweep_empty = (nr < CNT_W'(2)) || (nc == '0);
        status.c_first     = (c_reg == '0);
        status.c_last      = ((CNT_W'(c_reg) + CNT_W'(1)) == nc);
        status.r_last      = (r_reg == RW'(1));
        status.clr_last    = (clr_reg == AW'(DEPTH - 1));
        status.out_free    = !ov_reg || out_ready;
    end

    assign out_valid = ov_reg;
    assign out_data  = {6'b0, oop_reg, oc_reg};

endmodule

[rtl/core/falling_cell_grid_sweep_top.sv]
// A write or read item goes from accept to result valid through the controller states;
// a fall item visits each cell above the bottom row in turn, bottom rows first, with
// every access on the single port of the grid RAM.
// One item at a time; the next item is taken while a result waits in the output stage.
// Reset: asynchronous, active low; registers return to 64, then a clearing pass
// writes space to all MAX_ROWS*MAX_COLS cells (one per cycle) before items are taken.
module falling_cell_grid_sweep_top #(
    parameter int MAX_ROWS = fcgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = fcgs_pkg::DEF_MAX_COLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: opcode[1:0], row[7:2], col[13:8], char_in[21:14], zero [23:22]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fcgs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // tdata: char_out[7:0], op_done[9:8], zero [15:10]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fcgs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fcgs_pkg::APB_AW-1:0]      paddr,
    input  logic [fcgs_pkg::APB_DW-1:0]      pwdata,
    output logic [fcgs_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import fcgs_pkg::*;

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [CFG_W-1:0] cols_cfg;
    logic [CFG_W-1:0] rows_cfg;

    fcgs_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cols_cfg (cols_cfg),
        .rows_cfg (rows_cfg)
    );

    fcgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fcgs_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cols_cfg  (cols_cfg),
        .rows_cfg  (rows_cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
